[sv/rcse_pkg.sv]
// ----------------------------------------------------------------------------
// rcse_pkg
// Shared constants, types and rounding helpers for the RC stick scale and
// expo core: formats, register indexes, curve modes and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package rcse_pkg;

    // Command format: signed Q2.14
    localparam int FRAC_BITS = 14;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam int CMD_W     = 16;

    // Register and field widths
    localparam int PULSE_W   = 12;
    localparam int DB_W      = 15;
    localparam int MODE_W    = 2;
    localparam int EXPO_W    = 21;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0] RST_MID_PULSE = PULSE_W'(1500);
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE = PULSE_W'(2000);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE  = 3'd0,
        REG_MID_PULSE  = 3'd1,
        REG_MAX_PULSE  = 3'd2,
        REG_DEAD_BAND  = 3'd3,
        REG_CURVE_MODE = 3'd4,
        REG_EXPO       = 3'd5
    } t_reg_idx;

    // Curve selection; the last code behaves as no curve
    typedef enum logic [MODE_W-1:0] {
        CURVE_NONE     = 2'd0,
        CURVE_PCT_EXPO = 2'd1,
        CURVE_CUBIC    = 2'd2,
        CURVE_NONE_ALT = 2'd3
    } t_curve_mode;

    // Range divider: quotient bits kept before saturation, steps per stage
    localparam int Q_BITS     = 18;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int NUM_W      = PULSE_W + FRAC_BITS + 1;
    localparam int HI_W       = NUM_W - Q_BITS;
    localparam int RNG_W      = Q_BITS + 2;

    // Percent divide: x/(100*ONE) as a shift, then a reciprocal multiply
    localparam int PCT_DIV   = 100;
    localparam int PCT_HALF  = (PCT_DIV * ONE_I) / 2;
    localparam int RECIP_SH  = 29;
    localparam int RECIP     = ((1 << RECIP_SH) + PCT_DIV - 1) / PCT_DIV;
    localparam int RECIP_W   = 23;

    // Pipeline depths: prep, divider seed, divider stages, post; then curve
    localparam int MAP_STAGES   = DIV_STAGES + 3;
    localparam int CURVE_STAGES = 8;
    localparam int LATENCY      = MAP_STAGES + CURVE_STAGES;

    // Wide working width for the rounding helpers
    localparam int WIDE_W = 48;
    localparam logic signed [WIDE_W-1:0] ONE_W     = WIDE_W'(ONE_I);
    localparam logic signed [WIDE_W-1:0] NEG_ONE_W = -WIDE_W'(ONE_I);

    // Configuration registers as one bundle
    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] mid_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [DB_W-1:0]    dead_band;
        t_curve_mode        curve_mode;
        logic [EXPO_W-1:0]  expo;
    } t_cfg;

    // One beat in flight through the range divider
    typedef struct packed {
        logic [PULSE_W-1:0] rem;
        logic [Q_BITS-1:0]  low;
        logic [Q_BITS-1:0]  quo;
        logic [PULSE_W-1:0] den;
        logic               neg_q;
        logic               lower_half;
        logic               zero_span;
        logic               ovf;
    } t_div_beat;

    // Command beat from the mapper to the curve pipeline
    typedef struct packed {
        logic                    vld;
        logic signed [CMD_W-1:0] cmd;
    } t_cmd_beat;

    // Result beat at the end of the curve pipeline
    typedef struct packed {
        logic                    vld;
        logic signed [CMD_W-1:0] true_cmd;
        logic signed [CMD_W-1:0] curved_cmd;
    } t_res_beat;

    // Divide by ONE, rounding to nearest with ties away from zero
    function automatic logic signed [WIDE_W-1:0] rnd_frac(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] q;
        mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        q   = (mag + WIDE_W'(ONE_I / 2)) >> FRAC_BITS;
        return v[WIDE_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // Saturate to plus or minus ONE
    function automatic logic signed [CMD_W-1:0] clamp_one(input logic signed [WIDE_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        if (v > ONE_W) begin
            r = CMD_W'(ONE_I);
        end else if (v < NEG_ONE_W) begin
            r = -CMD_W'(ONE_I);
        end else begin
            r = v[CMD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/rcse_div_stage.sv]
// ----------------------------------------------------------------------------
// rcse_div_stage
// One registered stage of the restoring range divider; retires DIV_STEPS
// quotient bits per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rcse_div_stage
    import rcse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_vld,
    input  wire t_div_beat i_beat,
    output logic           o_vld,
    output t_div_beat      o_beat
);

    t_div_beat n_beat;
    t_div_beat r_beat;
    logic      r_vld;

    // Shift in one dividend bit per step, subtract where the divisor fits
    always_comb begin
        logic [PULSE_W:0] rem_sh;
        n_beat = i_beat;
        for (int k = 0; k < DIV_STEPS; k++) begin
            rem_sh     = {n_beat.rem, n_beat.low[Q_BITS-1]};
            n_beat.low = {n_beat.low[Q_BITS-2:0], 1'b0};
            if (rem_sh >= {1'b0, n_beat.den}) begin
                n_beat.rem = PULSE_W'(rem_sh - {1'b0, n_beat.den});
                n_beat.quo = {n_beat.quo[Q_BITS-2:0], 1'b1};
            end else begin
                n_beat.rem = rem_sh[PULSE_W-1:0];
                n_beat.quo = {n_beat.quo[Q_BITS-2:0], 1'b0};
            end
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;

endmodule

`default_nettype wire

[sv/rcse_map.sv]
// ----------------------------------------------------------------------------
// rcse_map
// Pulse to command mapper: picks the half range, divides by the span in a
// staged restoring divider, then applies deadband and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rcse_map
    import rcse_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [PULSE_W-1:0] i_raw_pulse,
    input  wire t_cfg               i_cfg,
    output t_cmd_beat               o_beat
);

    // ---- prep: half range selection and operand magnitudes ----
    logic                      w_lower;
    logic [PULSE_W-1:0]        w_lo;
    logic [PULSE_W-1:0]        w_hi;
    logic signed [PULSE_W:0]   w_diff;
    logic signed [PULSE_W:0]   w_span;
    logic [PULSE_W-1:0]        w_diff_mag;
    logic [PULSE_W-1:0]        w_span_mag;
    logic [NUM_W-1:0]          n_numer;

    assign w_lower    = i_raw_pulse < i_cfg.mid_pulse;
    assign w_lo       = w_lower ? i_cfg.min_pulse : i_cfg.mid_pulse;
    assign w_hi       = w_lower ? i_cfg.mid_pulse : i_cfg.max_pulse;
    assign w_diff     = $signed({1'b0, i_raw_pulse}) - $signed({1'b0, w_lo});
    assign w_span     = $signed({1'b0, w_hi}) - $signed({1'b0, w_lo});
    assign w_diff_mag = w_diff[PULSE_W] ? PULSE_W'(-w_diff) : w_diff[PULSE_W-1:0];
    assign w_span_mag = w_span[PULSE_W] ? PULSE_W'(-w_span) : w_span[PULSE_W-1:0];
    // numerator magnitude plus half the divisor gives round to nearest
    assign n_numer    = NUM_W'({w_diff_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(w_span_mag >> 1);

    logic               r_p_vld;
    logic [NUM_W-1:0]   r_p_numer;
    logic [PULSE_W-1:0] r_p_den;
    logic               r_p_neg_q;
    logic               r_p_lower;
    logic               r_p_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_numer <= n_numer;
        r_p_den   <= w_span_mag;
        r_p_neg_q <= w_diff[PULSE_W] ^ w_span[PULSE_W];
        r_p_lower <= w_lower;
        r_p_zero  <= (w_span == '0);
    end

    // ---- divider seed: overflow check and first partial remainder ----
    logic [PULSE_W-1:0] w_top;
    logic               w_ovf;
    t_div_beat          n_seed;
    t_div_beat          w_beat [DIV_STAGES+1];
    logic               w_vld  [DIV_STAGES+1];
    logic               r_s_vld;
    t_div_beat          r_s_beat;

    assign w_top = {{(PULSE_W-HI_W){1'b0}}, r_p_numer[NUM_W-1:Q_BITS]};
    assign w_ovf = w_top >= r_p_den;

    always_comb begin
        n_seed.rem        = w_ovf ? '0 : w_top;
        n_seed.low        = r_p_numer[Q_BITS-1:0];
        n_seed.quo        = '0;
        n_seed.den        = r_p_den;
        n_seed.neg_q      = r_p_neg_q;
        n_seed.lower_half = r_p_lower;
        n_seed.zero_span  = r_p_zero;
        n_seed.ovf        = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_beat <= n_seed;
    end

    assign w_vld[0]  = r_s_vld;
    assign w_beat[0] = r_s_beat;

    // ---- divider stages ----
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        rcse_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_beat  (w_beat[g]),
            .o_vld   (w_vld[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // ---- post: sign, half range offset, deadband, clamp ----
    t_div_beat                w_last;
    logic [Q_BITS-1:0]        w_q_sat;
    logic signed [RNG_W-1:0]  w_q_sgn;
    logic signed [RNG_W-1:0]  w_ranged;
    logic [RNG_W-1:0]         w_mag;
    logic signed [CMD_W-1:0]  n_cmd;
    logic                     r_o_vld;
    logic signed [CMD_W-1:0]  r_o_cmd;

    assign w_last   = w_beat[DIV_STAGES];
    assign w_q_sat  = w_last.ovf ? '1 : w_last.quo;
    assign w_q_sgn  = w_last.neg_q ? -$signed({2'b00, w_q_sat}) : $signed({2'b00, w_q_sat});
    assign w_ranged = w_last.zero_span ? '0 :
                      (w_q_sgn - (w_last.lower_half ? RNG_W'(ONE_I) : '0));
    assign w_mag    = w_ranged[RNG_W-1] ? RNG_W'(-w_ranged) : RNG_W'(w_ranged);
    assign n_cmd    = (w_mag > RNG_W'(i_cfg.dead_band)) ? clamp_one(WIDE_W'(w_ranged)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_cmd <= n_cmd;
    end

    assign o_beat.vld = r_o_vld;
    assign o_beat.cmd = r_o_cmd;

endmodule

`default_nettype wire

[sv/rcse_curve.sv]
// ----------------------------------------------------------------------------
// rcse_curve
// Eight stage curve pipeline: percent expo and blended cubic computed side
// by side, at most one multiplier layer per stage, selected at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcse_curve
    import rcse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd_beat         i_beat,
    input  wire t_curve_mode       i_curve_mode,
    input  wire logic [EXPO_W-1:0] i_expo,
    output t_res_beat              o_beat
);

    localparam int SQ_W   = 2 * FRAC_BITS + 1;
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int P1_W   = EXPO_W + MAG_W;
    localparam int P2_W   = 2 * FRAC_BITS + 2;
    localparam int A_W    = P1_W - FRAC_BITS;
    localparam int DIFF_W = CMD_W + 1;
    localparam int QM_W   = A_W + RECIP_W;
    localparam int P3_W   = EXPO_W + DIFF_W + 1;
    localparam int Q100_W = QM_W - RECIP_SH;
    localparam int F_W    = CMD_W + 1;
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1 << (2 * FRAC_BITS));
    localparam logic [SQ_W-1:0] HALF   = SQ_W'(ONE_I / 2);

    // Valid and command travel alongside the arithmetic
    logic [CURVE_STAGES-1:0]  r_vld;
    logic signed [CMD_W-1:0]  r_x [CURVE_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CURVE_STAGES-2:0], i_beat.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= i_beat.cmd;
        for (int k = 1; k < CURVE_STAGES; k++) begin
            r_x[k] <= r_x[k-1];
        end
    end

    // Stage 1: square
    logic signed [2*CMD_W-1:0] w_sq;
    logic [SQ_W-1:0]           r1_sq;
    assign w_sq = i_beat.cmd * i_beat.cmd;
    always_ff @(posedge i_clk) begin
        r1_sq <= w_sq[SQ_W-1:0];
    end

    // Stage 2: x*x - 1 (as magnitude) and x*x, both rounded to Q14
    logic [MAG_W-1:0] r2_dmag;
    logic [MAG_W-1:0] r2_x2;
    logic [SQ_W-1:0]  w_dsum;
    logic [SQ_W-1:0]  w_ssum;
    assign w_dsum = (ONE_SQ - r1_sq) + HALF;
    assign w_ssum = r1_sq + HALF;
    always_ff @(posedge i_clk) begin
        r2_dmag <= w_dsum[SQ_W-1:FRAC_BITS];
        r2_x2   <= w_ssum[SQ_W-1:FRAC_BITS];
    end

    // Stage 3: expo times the magnitude, x2 times x
    logic [P1_W-1:0]              w_p1;
    logic signed [CMD_W+MAG_W:0]  w_p2;
    logic [P1_W-1:0]              r3_p1;
    logic signed [P2_W-1:0]       r3_p2;
    assign w_p1 = i_expo * r2_dmag;
    assign w_p2 = $signed({1'b0, r2_x2}) * r_x[1];
    always_ff @(posedge i_clk) begin
        r3_p1 <= w_p1;
        r3_p2 <= w_p2[P2_W-1:0];
    end

    // Stage 4: divide the expo product by ONE with rounding; cube minus x
    logic [P1_W-1:0]            w_asum;
    logic signed [WIDE_W-1:0]   w_x3;
    logic [A_W-1:0]             r4_a;
    logic signed [DIFF_W-1:0]   r4_diff;
    assign w_asum = r3_p1 + P1_W'(PCT_HALF);
    assign w_x3   = rnd_frac(WIDE_W'(r3_p2));
    always_ff @(posedge i_clk) begin
        r4_a    <= w_asum[P1_W-1:FRAC_BITS];
        r4_diff <= DIFF_W'(w_x3) - DIFF_W'(r_x[2]);
    end

    // Stage 5: reciprocal multiply for the percent; expo times (x3 - x)
    logic [QM_W-1:0]          w_qm;
    logic signed [P3_W-1:0]   w_p3;
    logic [QM_W-1:0]          r5_qm;
    logic signed [P3_W-1:0]   r5_p3;
    assign w_qm = r4_a * RECIP_W'(RECIP);
    assign w_p3 = $signed({1'b0, i_expo}) * r4_diff;
    always_ff @(posedge i_clk) begin
        r5_qm <= w_qm;
        r5_p3 <= w_p3;
    end

    // Stage 6: expo factor; cubic blend finished and saturated
    logic [Q100_W-1:0]        w_q100;
    logic signed [F_W-1:0]    r6_f;
    logic signed [CMD_W-1:0]  r6_y2;
    assign w_q100 = r5_qm[QM_W-1:RECIP_SH];
    always_ff @(posedge i_clk) begin
        r6_f  <= $signed(F_W'(ONE_I)) - $signed({1'b0, w_q100});
        r6_y2 <= clamp_one(WIDE_W'(r_x[4]) + rnd_frac(WIDE_W'(r5_p3)));
    end

    // Stage 7: factor times x
    logic signed [F_W+CMD_W-1:0] w_p4;
    logic signed [P2_W-1:0]      r7_p4;
    logic signed [CMD_W-1:0]     r7_y2;
    assign w_p4 = r6_f * r_x[5];
    always_ff @(posedge i_clk) begin
        r7_p4 <= w_p4[P2_W-1:0];
        r7_y2 <= r6_y2;
    end

    // Stage 8: round and saturate the expo result, pick by mode
    logic signed [CMD_W-1:0] n_y;
    logic signed [CMD_W-1:0] r8_y;
    always_comb begin
        case (i_curve_mode)
            CURVE_PCT_EXPO: n_y = clamp_one(rnd_frac(WIDE_W'(r7_p4)));
            CURVE_CUBIC:    n_y = r7_y2;
            default:        n_y = r_x[6];
        endcase
    end
    always_ff @(posedge i_clk) begin
        r8_y <= n_y;
    end

    assign o_beat.vld        = r_vld[CURVE_STAGES-1];
    assign o_beat.true_cmd   = r_x[CURVE_STAGES-1];
    assign o_beat.curved_cmd = r8_y;

endmodule

`default_nettype wire

[sv/rc_stick_scale_expo_core.sv]
// ----------------------------------------------------------------------------
// rc_stick_scale_expo_core
// One RC stick channel: raw pulse width to deadbanded command and curved
// command in signed Q2.14.
//
//   channel   direction  signals                              beat when
//   command   in         start, busy, i_raw_pulse             start && !busy
//   result    out        o_strobe, o_true_command,            o_strobe
//                        o_curved_command
//   config    in         i_cfg_we, i_cfg_idx, i_cfg_data      i_cfg_we
//
// A new pulse may be taken every cycle; its result passes through prep, the divider
// seed, six divider stages of three quotient bits, post, then eight curve stages.
// Reset is synchronous, active low; busy is high in reset and the first cycle after.
// The result strobe lasts one cycle and cannot be held off; nothing stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_stick_scale_expo_core
    import rcse_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [PULSE_W-1:0]   i_raw_pulse,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_strobe,
    output logic signed [CMD_W-1:0]   o_true_command,
    output logic signed [CMD_W-1:0]   o_curved_command
);

    t_cfg      r_cfg;
    logic      r_busy;
    logic      w_accept;
    t_cmd_beat w_cmd;
    t_res_beat w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse  <= RST_MIN_PULSE;
            r_cfg.mid_pulse  <= RST_MID_PULSE;
            r_cfg.max_pulse  <= RST_MAX_PULSE;
            r_cfg.dead_band  <= '0;
            r_cfg.curve_mode <= CURVE_NONE;
            r_cfg.expo       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_PULSE:  r_cfg.min_pulse  <= i_cfg_data[PULSE_W-1:0];
                REG_MID_PULSE:  r_cfg.mid_pulse  <= i_cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:  r_cfg.max_pulse  <= i_cfg_data[PULSE_W-1:0];
                REG_DEAD_BAND:  r_cfg.dead_band  <= i_cfg_data[DB_W-1:0];
                REG_CURVE_MODE: r_cfg.curve_mode <= t_curve_mode'(i_cfg_data[MODE_W-1:0]);
                REG_EXPO:       r_cfg.expo       <= i_cfg_data[EXPO_W-1:0];
                default: ;
            endcase
        end
    end

    // Busy only while coming out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start & ~r_busy;

    // Mapping and deadband
    rcse_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_accept),
        .i_raw_pulse (i_raw_pulse),
        .i_cfg       (r_cfg),
        .o_beat      (w_cmd)
    );

    // Curve shaping
    rcse_curve u_curve (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (w_cmd),
        .i_curve_mode (r_cfg.curve_mode),
        .i_expo       (r_cfg.expo),
        .o_beat       (w_res)
    );

    assign o_strobe         = w_res.vld;
    assign o_true_command   = w_res.true_cmd;
    assign o_curved_command = w_res.curved_cmd;

    // Every accepted pulse gives its result after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_strobe)
        else $error("accepted beat produced no result");

    // No result without a beat accepted the same latency earlier
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LATENCY))
        else $error("result without accepted beat");

    // Both commands stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_true_command <= CMD_W'(ONE_I)) && (o_true_command >= -CMD_W'(ONE_I))
                  && (o_curved_command <= CMD_W'(ONE_I))
                  && (o_curved_command >= -CMD_W'(ONE_I)))
        else $error("command out of range");

    // Zero in gives zero out; no curve passes the command through
    a_curve_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ((o_true_command == '0) || (r_cfg.curve_mode == CURVE_NONE)
                     || (r_cfg.curve_mode == CURVE_NONE_ALT))
        |-> o_curved_command == o_true_command)
        else $error("curve output mismatch on zero or pass-through");

endmodule

`default_nettype wire

[dv/tb_rc_stick_scale_expo_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_stick_scale_expo_core
// Self-checking bench for one RC stick channel. Every pulse beat taken by the
// core is run through a local fixed-point model of the range mapping,
// deadband, clamp and curve shaping. The model's answer is queued and
// compared field by field with each result strobe. A short directed part
// covers the ends of the pulse range, every curve mode and the corner cases.
// Random phases then follow, each with a fresh register set, including the
// register extremes and varying amounts of sender idling.
// ----------------------------------------------------------------------------

module tb_rc_stick_scale_expo_core;
    import rcse_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 14;
    localparam int PHASE_BEATS    = 100;

    typedef struct {
        logic [PULSE_W-1:0]      raw;
        logic signed [CMD_W-1:0] true_cmd;
        logic signed [CMD_W-1:0] curved_cmd;
    } t_cmd_pair;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [PULSE_W-1:0]        i_raw_pulse;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      o_strobe;
    logic signed [CMD_W-1:0]   o_true_command;
    logic signed [CMD_W-1:0]   o_curved_command;

    // Shadow of the core's registers, kept in step with every write
    t_cfg      cfg_model;
    t_cmd_pair cmd_pending_q[$];
    int        bad_beats   = 0;
    int        idle_pct    = 0;
    int        quiet_count = 0;

    rc_stick_scale_expo_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_raw_pulse     (i_raw_pulse),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_true_command  (o_true_command),
        .o_curved_command(o_curved_command)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // Divide, rounding to nearest with ties away from zero
    function automatic longint round_div(input longint n, input longint d);
        bit     neg;
        longint q;
        neg = 1'b0;
        if (d < 0) begin
            d   = -d;
            neg = ~neg;
        end
        if (n < 0) begin
            n   = -n;
            neg = ~neg;
        end
        q = (n + d / 2) / d;
        return neg ? -q : q;
    endfunction

    function automatic longint sat_one(input longint v);
        longint one;
        one = ONE_I;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    // Pulse width to true and curved command under the current registers
    function automatic t_cmd_pair shape_stick(input logic [PULSE_W-1:0] raw);
        t_cmd_pair r;
        longint    one, lo, hi, ranged, mag, t, c, e, d, f, x2, x3;
        bit        lower;
        one   = ONE_I;
        e     = cfg_model.expo;
        t     = 0;
        c     = 0;
        lower = raw < cfg_model.mid_pulse;
        if (lower) begin
            lo = cfg_model.min_pulse;
            hi = cfg_model.mid_pulse;
        end else begin
            lo = cfg_model.mid_pulse;
            hi = cfg_model.max_pulse;
        end
        // zero span gives centre; a reversed span divides as signed
        if (hi == lo) begin
            ranged = 0;
        end else begin
            ranged = round_div((longint'(raw) - lo) * one, hi - lo);
            if (lower) ranged -= one;
        end
        mag = (ranged < 0) ? -ranged : ranged;
        if (mag > longint'(cfg_model.dead_band)) begin
            t = sat_one(ranged);
            case (cfg_model.curve_mode)
                CURVE_PCT_EXPO: begin
                    d = round_div(t * t - one * one, one);
                    f = one + round_div(e * d, PCT_DIV * one);
                    c = sat_one(round_div(f * t, one));
                end
                CURVE_CUBIC: begin
                    x2 = round_div(t * t, one);
                    x3 = round_div(x2 * t, one);
                    c  = sat_one(t + round_div(e * (x3 - t), one));
                end
                default: c = t;
            endcase
        end
        r.raw        = raw;
        r.true_cmd   = t[CMD_W-1:0];
        r.curved_cmd = c[CMD_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write; the shadow keeps only the register's own bits
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MIN_PULSE:  cfg_model.min_pulse  = data[PULSE_W-1:0];
            REG_MID_PULSE:  cfg_model.mid_pulse  = data[PULSE_W-1:0];
            REG_MAX_PULSE:  cfg_model.max_pulse  = data[PULSE_W-1:0];
            REG_DEAD_BAND:  cfg_model.dead_band  = data[DB_W-1:0];
            REG_CURVE_MODE: cfg_model.curve_mode = t_curve_mode'(data[MODE_W-1:0]);
            REG_EXPO:       cfg_model.expo       = data[EXPO_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_span(input int lo, input int mid, input int hi);
        write_reg(REG_MIN_PULSE, CFG_W'(lo));
        write_reg(REG_MID_PULSE, CFG_W'(mid));
        write_reg(REG_MAX_PULSE, CFG_W'(hi));
    endtask

    // Random idle cycles ahead of a beat; data wanders while start is low
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            i_raw_pulse <= PULSE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // One pulse beat; start is left high so back-to-back beats stay high
    task automatic send_pulse(input logic [PULSE_W-1:0] raw);
        sender_gap();
        start       <= 1'b1;
        i_raw_pulse <= raw;
        do @(posedge i_clk); while (busy);
        cmd_pending_q.push_back(shape_stick(raw));
    endtask

    // Stop sending and hold until every queued result has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (cmd_pending_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_pair want;
        if (i_rst_n && o_strobe) begin
            if (cmd_pending_q.size() == 0) begin
                bad_beats++;
                $display("%0t: result with none pending: true %0d curved %0d",
                         $time, o_true_command, o_curved_command);
            end else begin
                want = cmd_pending_q.pop_front();
                if (o_true_command !== want.true_cmd) begin
                    bad_beats++;
                    $display("%0t: raw %0d true_command expected %0d actual %0d",
                             $time, want.raw, want.true_cmd, o_true_command);
                end
                if (o_curved_command !== want.curved_cmd) begin
                    bad_beats++;
                    $display("%0t: raw %0d curved_command expected %0d actual %0d",
                             $time, want.raw, want.curved_cmd, o_curved_command);
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_count);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: ends of the range, centre and beyond
    task automatic test_reset_mapping();
        send_pulse(12'd0);
        send_pulse(12'd1000);
        send_pulse(12'd1250);
        send_pulse(12'd1499);
        send_pulse(12'd1500);
        send_pulse(12'd1750);
        send_pulse(12'd2000);
        send_pulse(12'd4095);
    endtask

    // Each curve mode on a few deflections
    task automatic test_curve_modes();
        t_curve_mode modes[4];
        modes = '{CURVE_NONE, CURVE_PCT_EXPO, CURVE_CUBIC, CURVE_NONE_ALT};
        foreach (modes[m]) begin
            settle();
            write_reg(REG_CURVE_MODE, CFG_W'(modes[m]));
            // 50 percent for the expo curve, one half for the cubic
            write_reg(REG_EXPO, (modes[m] == CURVE_PCT_EXPO) ? CFG_W'(819200)
                                                               : CFG_W'(8192));
            send_pulse(12'd1200);
            send_pulse(12'd1833);
            send_pulse(12'd1980);
        end
    endtask

    task automatic test_special_cases();
        // zero span on the lower half
        settle();
        set_span(1500, 1500, 2000);
        send_pulse(12'd1200);
        // reversed span on the upper half
        settle();
        set_span(1000, 1500, 1000);
        send_pulse(12'd1700);
        // cubic with expo at 100.0, far past a full blend, saturates
        settle();
        set_span(RST_MIN_PULSE, RST_MID_PULSE, RST_MAX_PULSE);
        write_reg(REG_CURVE_MODE, CFG_W'(CURVE_CUBIC));
        write_reg(REG_EXPO, CFG_W'(1638400));
        send_pulse(12'd1600);
        // magnitude equal to the deadband stays zero
        settle();
        write_reg(REG_DEAD_BAND, CFG_W'(1638));
        send_pulse(12'd1550);
        send_pulse(12'd1551);
        settle();
        write_reg(REG_DEAD_BAND, CFG_W'(16384));
        send_pulse(12'd2000);
    endtask

    function automatic logic [CFG_W-1:0] with_junk(input int val, input int w);
        logic [CFG_W-1:0] j;
        j = CFG_W'($urandom);
        j = (j >> w) << w;
        return j | CFG_W'(val);
    endfunction

    // Fresh register set for one random phase; the first two are extremes
    task automatic load_phase_config(input int k);
        int lo, mid, hi, db, ex;
        int mode;
        if (k == 0) begin
            lo = 0; mid = 0; hi = 0; db = 0; ex = 0; mode = CURVE_PCT_EXPO;
        end else if (k == 1) begin
            lo = 4095; mid = 4095; hi = 4095; db = 32767; ex = 2097151;
            mode = CURVE_NONE_ALT;
        end else begin
            mode = $urandom_range(3);
            case ($urandom_range(5))
                0, 1, 2: begin
                    lo  = $urandom_range(1200, 800);
                    mid = lo + $urandom_range(700, 300);
                    hi  = mid + $urandom_range(700, 300);
                end
                3: begin
                    lo  = 0;
                    mid = 2048;
                    hi  = 4095;
                end
                4: begin
                    lo  = $urandom_range(4095);
                    mid = $urandom_range(4095);
                    hi  = $urandom_range(4095);
                end
                default: begin
                    lo  = $urandom_range(1200, 800);
                    mid = $urandom_range(1) ? lo : lo + 500;
                    hi  = (mid == lo) ? mid + 500 : mid;
                end
            endcase
            case ($urandom_range(5))
                0:       db = 16384;
                1:       db = $urandom_range(32767);
                2, 3:    db = $urandom_range(2000);
                default: db = 0;
            endcase
            case ($urandom_range(4))
                0:       ex = 1638400;
                1:       ex = $urandom_range(2097151);
                2:       ex = 0;
                default: ex = (mode == CURVE_PCT_EXPO) ? $urandom_range(1638400)
                                                       : $urandom_range(16384);
            endcase
        end
        write_reg(REG_MIN_PULSE,  with_junk(lo, PULSE_W));
        write_reg(REG_MID_PULSE,  with_junk(mid, PULSE_W));
        write_reg(REG_MAX_PULSE,  with_junk(hi, PULSE_W));
        write_reg(REG_DEAD_BAND,  with_junk(db, DB_W));
        write_reg(REG_CURVE_MODE, with_junk(mode, MODE_W));
        write_reg(REG_EXPO,       with_junk(ex, EXPO_W));
    endtask

    // Pulse mostly inside the configured span, at times on a setpoint or anywhere
    function automatic logic [PULSE_W-1:0] pick_pulse();
        int a, b, p;
        a = cfg_model.min_pulse;
        b = cfg_model.min_pulse;
        if (cfg_model.mid_pulse < a) a = cfg_model.mid_pulse;
        if (cfg_model.max_pulse < a) a = cfg_model.max_pulse;
        if (cfg_model.mid_pulse > b) b = cfg_model.mid_pulse;
        if (cfg_model.max_pulse > b) b = cfg_model.max_pulse;
        a = (a > 40) ? a - 40 : 0;
        b = (b + 40 > 4095) ? 4095 : b + 40;
        case ($urandom_range(9))
            0: p = $urandom_range(4095);
            1: begin
                case ($urandom_range(2))
                    0:       p = cfg_model.min_pulse;
                    1:       p = cfg_model.mid_pulse;
                    default: p = cfg_model.max_pulse;
                endcase
                p = p + $urandom_range(2) - 1;
                if (p < 0) p = 0;
                if (p > 4095) p = 4095;
            end
            default: p = $urandom_range(b, a);
        endcase
        return PULSE_W'(p);
    endfunction

    task automatic test_random_phases();
        int pace[3];
        pace = '{0, 80, 28};
        for (int k = 0; k < PHASE_COUNT; k++) begin
            settle();
            load_phase_config(k);
            idle_pct = pace[k % 3];
            repeat (PHASE_BEATS) send_pulse(pick_pulse());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_raw_pulse <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_MIN_PULSE;
        i_cfg_data  <= '0;
        cfg_model.min_pulse  = RST_MIN_PULSE;
        cfg_model.mid_pulse  = RST_MID_PULSE;
        cfg_model.max_pulse  = RST_MAX_PULSE;
        cfg_model.dead_band  = '0;
        cfg_model.curve_mode = CURVE_NONE;
        cfg_model.expo       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_mapping();
        test_curve_modes();
        test_special_cases();
        test_random_phases();

        settle();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (cmd_pending_q.size() != 0) bad_beats++;
        if (bad_beats == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/rcse_pkg.sv
sv/rcse_div_stage.sv
sv/rcse_map.sv
sv/rcse_curve.sv
sv/rc_stick_scale_expo_core.sv
dv/tb_rc_stick_scale_expo_core.sv
